// ----- hw/rtl/u8d_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    localparam int unsigned CpWidth = 21;

    // code point emitted for bad or broken sequences
    localparam logic [CpWidth-1:0] ReplacementCp = 21'h00FFFD;

    // lead byte classes
    localparam logic [7:0] ContMask  = 8'hC0;
    localparam logic [7:0] ContCode  = 8'h80;
    localparam logic [7:0] Lead2Mask = 8'hE0;
    localparam logic [7:0] Lead2Code = 8'hC0;
    localparam logic [7:0] Lead3Mask = 8'hF0;
    localparam logic [7:0] Lead3Code = 8'hE0;
    localparam logic [7:0] Lead4Mask = 8'hF8;
    localparam logic [7:0] Lead4Code = 8'hF0;
    localparam logic [7:0] AsciiTop  = 8'h80;

    // payload masks
    localparam logic [7:0] ContBits  = 8'h3F;
    localparam logic [7:0] Lead2Bits = 8'h1F;
    localparam logic [7:0] Lead3Bits = 8'h0F;
    localparam logic [7:0] Lead4Bits = 8'h07;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } byte_beat_t;

    typedef struct packed {
        logic [CpWidth-1:0] code_point;
        logic               last_of_run;
        logic               string_done;
    } cp_beat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/utf8_stream_decoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Lenient UTF-8 stream decoder.
// Byte channel (byte_valid/byte_ready/byte_beat) carries one raw byte and an
// end-of-string flag per beat. Code point channel (cp_valid/cp_ready/cp_beat)
// carries decoded code points; last_of_run marks the final beat caused by a
// byte, string_done the final beat of a string.
// A byte lands in an input register, is decoded against the open sequence
// in one pass and the results (a run of U+FFFD plus an optional tail value)
// land in the result register, which drives cp_beat directly.
// An accepted byte waits in the input register until the result register is free.
// Throughput: one byte per cycle while each byte yields at most one code
// point and the receiver keeps cp_ready high; a byte yielding N code points
// holds the result register until all N beats are taken, so a broken sequence yields up to 4 beats.
// Bytes that only open or extend a sequence produce no beat.
// Reset clears the open sequence and the valid state of both registers (not their payloads); no clearing pass.
// When the receiver stalls, the result register holds its beat and the
// input register takes one more byte before byte_ready drops.
module utf8_stream_decoder_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_ready,
    input  wire u8d_pkg::byte_beat_t byte_beat,
    output logic                   cp_valid,
    input  wire logic              cp_ready,
    output u8d_pkg::cp_beat_t      cp_beat
);
    import u8d_pkg::*;

    // input register
    logic       in_valid_reg;
    byte_beat_t in_data_reg;

    // sequence state
    logic [CpWidth-1:0] partial_reg,  partial_next;
    logic [1:0]         needed_reg,   needed_next;
    logic [1:0]         gathered_reg, gathered_next;

    // result register: rep_cnt replacements, then optional tail
    logic [1:0]         rep_cnt_reg,  rep_cnt_next;
    logic               tail_vld_reg, tail_vld_next;
    logic [CpWidth-1:0] tail_cp_reg,  tail_cp_next;
    logic               eos_reg,      eos_next;

    logic job_empty;
    logic job_last;
    logic job_free;
    logic move;

    assign job_empty = (rep_cnt_reg == 2'd0) && !tail_vld_reg;
    assign job_last  = ((rep_cnt_reg == 2'd1) && !tail_vld_reg) ||
                       ((rep_cnt_reg == 2'd0) && tail_vld_reg);
    assign job_free  = job_empty || (job_last && cp_ready);
    assign move      = in_valid_reg && job_free;
    assign byte_ready = !in_valid_reg || job_free;

    // output drive
    assign cp_valid = !job_empty;
    always_comb
    begin
        cp_beat.code_point  = (rep_cnt_reg != 2'd0) ? ReplacementCp : tail_cp_reg;
        cp_beat.last_of_run = job_last;
        cp_beat.string_done = job_last && eos_reg;
    end

    // decode one byte against the open sequence
    logic [7:0]         b;
    logic               eos;
    logic               is_cont;
    logic               fresh;
    logic [CpWidth-1:0] ext_val;
    logic [1:0]         g1;
    logic [1:0]         need;
    logic [7:0]         bits;
    logic [1:0]         d_rep;
    logic               d_tail;
    logic [CpWidth-1:0] d_cp;

    always_comb
    begin
        b       = in_data_reg.in_byte;
        eos     = in_data_reg.end_of_string;
        is_cont = (b & ContMask) == ContCode;
        ext_val = {partial_reg[CpWidth-7:0], b[5:0] & ContBits[5:0]};
        g1      = gathered_reg + 2'd1;
        fresh   = 1'b1;
        d_rep   = 2'd0;
        d_tail  = 1'b0;
        d_cp    = ReplacementCp;
        partial_next  = partial_reg;
        needed_next   = needed_reg;
        gathered_next = gathered_reg;
        need = 2'd0;
        bits = 8'd0;

        // open sequence: extend, complete or break
        if (needed_reg != 2'd0)
        begin
            partial_next  = '0;
            needed_next   = 2'd0;
            gathered_next = 2'd0;
            if (is_cont)
            begin
                fresh = 1'b0;
                if (g1 >= needed_reg)
                begin
                    d_tail = 1'b1;
                    d_cp   = ext_val;
                end
                else if (eos)
                begin
                    // lead plus gathered continuations, this one included
                    d_rep = g1 + 2'd1;
                end
                else
                begin
                    partial_next  = ext_val;
                    needed_next   = needed_reg;
                    gathered_next = g1;
                end
            end
            else
            begin
                d_rep = gathered_reg + 2'd1;
            end
        end

        // fresh decode
        if (fresh)
        begin
            if (b < AsciiTop)
            begin
                d_tail = 1'b1;
                d_cp   = {{(CpWidth-8){1'b0}}, b};
            end
            else
            begin
                if ((b & Lead2Mask) == Lead2Code)
                begin
                    need = 2'd1;
                    bits = b & Lead2Bits;
                end
                else if ((b & Lead3Mask) == Lead3Code)
                begin
                    need = 2'd2;
                    bits = b & Lead3Bits;
                end
                else if ((b & Lead4Mask) == Lead4Code)
                begin
                    need = 2'd3;
                    bits = b & Lead4Bits;
                end
                if ((need == 2'd0) || eos)
                begin
                    d_tail = 1'b1;
                    d_cp   = ReplacementCp;
                end
                else
                begin
                    partial_next  = {{(CpWidth-8){1'b0}}, bits};
                    needed_next   = need;
                    gathered_next = 2'd0;
                end
            end
        end
    end

    // result register next value
    always_comb
    begin
        rep_cnt_next  = rep_cnt_reg;
        tail_vld_next = tail_vld_reg;
        tail_cp_next  = tail_cp_reg;
        eos_next      = eos_reg;
        if (move)
        begin
            rep_cnt_next  = d_rep;
            tail_vld_next = d_tail;
            tail_cp_next  = d_cp;
            eos_next      = eos;
        end
        else if (cp_valid && cp_ready)
        begin
            if (rep_cnt_reg != 2'd0)
            begin
                rep_cnt_next = rep_cnt_reg - 2'd1;
            end
            else
            begin
                tail_vld_next = 1'b0;
            end
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            partial_reg  <= '0;
            needed_reg   <= 2'd0;
            gathered_reg <= 2'd0;
            rep_cnt_reg  <= 2'd0;
            tail_vld_reg <= 1'b0;
            eos_reg      <= 1'b0;
        end
        else
        begin
            if (byte_ready)
            begin
                in_valid_reg <= byte_valid;
            end
            if (move)
            begin
                partial_reg  <= partial_next;
                needed_reg   <= needed_next;
                gathered_reg <= gathered_next;
            end
            rep_cnt_reg  <= rep_cnt_next;
            tail_vld_reg <= tail_vld_next;
            eos_reg      <= eos_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            in_data_reg <= byte_beat;
        end
        tail_cp_reg <= tail_cp_next;
    end

endmodule

`default_nettype wire

// ----- verif/tb_utf8_stream_decoder_unit.sv -----
`timescale 1ns / 1ps

module tb_utf8_stream_decoder_unit;
    import u8d_pkg::*;

    localparam int StallLimit = 2000;
    localparam int RandomPerPhase = 160;
    localparam int DrainCycles = 10;
    localparam int LongHoldCycles = 100;
    localparam int LongHoldAfter = 70;

    typedef enum logic [1:0] {
        RX_FULL,
        RX_MOSTLY,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_t;

    logic       clk;
    logic       rst_n;
    logic       byte_valid = 1'b0;
    logic       byte_ready;
    byte_beat_t byte_beat = '0;
    logic       cp_valid;
    logic       cp_ready = 1'b0;
    cp_beat_t   cp_beat;

    // stimulus and expectation stores
    byte_beat_t pending_bytes[$];
    cp_beat_t   expected_cps[$];

    // decoder shadow state
    logic [CpWidth-1:0] open_value = '0;
    logic [1:0]         open_need = '0;
    logic [1:0]         open_got = '0;

    // sender pacing
    int burst_left = 0;
    int gap_left = 0;
    int bytes_in = 0;

    // receiver pacing
    rx_mode_t ready_mode = RX_FULL;
    int       mode_timer = 0;
    int       hold_left = 0;
    logic     held_once = 1'b0;

    // bookkeeping
    int error_count = 0;
    int cps_checked = 0;
    int fffd_expected = 0;
    int strings_seen = 0;
    int idle_cycles = 0;

    utf8_stream_decoder_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_beat  (byte_beat),
        .cp_valid   (cp_valid),
        .cp_ready   (cp_ready),
        .cp_beat    (cp_beat)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Decode one accepted byte against the shadow state, queue its code points
    task automatic predict_byte(input byte_beat_t bb);
        logic [7:0]         b;
        logic               eos;
        logic               fresh;
        logic               broken;
        logic [1:0]         need;
        logic [CpWidth-1:0] bits;
        logic [CpWidth-1:0] cps [0:3];
        int                 n;
        int                 i;
        cp_beat_t           e;
        b = bb.in_byte;
        eos = bb.end_of_string;
        n = 0;
        fresh = 1'b1;
        broken = 1'b0;

        // continue or break an open sequence
        if (open_need != 0)
        begin
            if ((b & ContMask) == ContCode)
            begin
                fresh = 1'b0;
                open_value = {open_value[CpWidth-7:0], b[5:0]};
                open_got = open_got + 2'd1;
                if (open_got >= open_need)
                begin
                    cps[n] = open_value;
                    n++;
                    open_value = '0;
                    open_need = '0;
                    open_got = '0;
                end
                else if (eos)
                begin
                    broken = 1'b1;
                end
            end
            else
            begin
                broken = 1'b1;
            end
        end

        // one replacement for the lead, one per gathered continuation
        if (broken)
        begin
            for (i = 0; i <= int'(open_got); i++)
            begin
                cps[n] = ReplacementCp;
                n++;
            end
            open_value = '0;
            open_need = '0;
            open_got = '0;
        end

        // decode the byte on its own
        if (fresh)
        begin
            if (b < AsciiTop)
            begin
                cps[n] = CpWidth'(b);
                n++;
            end
            else
            begin
                need = 2'd0;
                bits = '0;
                if ((b & Lead2Mask) == Lead2Code)
                begin
                    need = 2'd1;
                    bits = CpWidth'(b & Lead2Bits);
                end
                else if ((b & Lead3Mask) == Lead3Code)
                begin
                    need = 2'd2;
                    bits = CpWidth'(b & Lead3Bits);
                end
                else if ((b & Lead4Mask) == Lead4Code)
                begin
                    need = 2'd3;
                    bits = CpWidth'(b & Lead4Bits);
                end
                if (need == 0 || eos)
                begin
                    cps[n] = ReplacementCp;
                    n++;
                end
                else
                begin
                    open_value = bits;
                    open_need = need;
                    open_got = '0;
                end
            end
        end

        for (i = 0; i < n; i++)
        begin
            e.code_point = cps[i];
            e.last_of_run = (i == n - 1);
            e.string_done = (i == n - 1) && eos;
            if (cps[i] == ReplacementCp)
                fffd_expected++;
            expected_cps.insert(expected_cps.size(), e);
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eos);
        byte_beat_t bb;
        bb.in_byte = b;
        bb.end_of_string = eos;
        pending_bytes.insert(pending_bytes.size(), bb);
    endtask

    // One random chunk: mostly well-formed text, some broken sequences and noise
    task automatic push_chunk();
        int         kind;
        int         need;
        int         keep;
        int         i;
        logic       eos;
        logic       early_end;
        logic [7:0] lead;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        eos = ($urandom_range(0, 7) == 0);
        need = $urandom_range(1, 3);
        case (need)
            1: lead = Lead2Code | 8'($urandom_range(0, 31));
            2: lead = Lead3Code | 8'($urandom_range(0, 15));
            default: lead = Lead4Code | 8'($urandom_range(0, 7));
        endcase
        if (kind < 40)
        begin
            push_byte(8'($urandom_range(0, 127)), eos);
        end
        else if (kind < 75)
        begin
            push_byte(lead, 1'b0);
            for (i = 0; i < need; i++)
                push_byte(ContCode | 8'($urandom_range(0, 63)), eos && (i == need - 1));
        end
        else if (kind < 90)
        begin
            keep = $urandom_range(0, need - 1);
            early_end = $urandom_range(0, 2) == 0;
            push_byte(lead, early_end && (keep == 0));
            for (i = 0; i < keep; i++)
                push_byte(ContCode | 8'($urandom_range(0, 63)), early_end && (i == keep - 1));
            if (!early_end)
            begin
                b = 8'($urandom_range(0, 255));
                if ((b & ContMask) == ContCode)
                    b = b ^ 8'h40;
                push_byte(b, eos);
            end
        end
        else
        begin
            push_byte(8'($urandom_range(0, 255)), eos);
        end
    endtask

    // Byte driver: bursts with random gaps, valid held until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_beat <= '0;
            burst_left <= 0;
            gap_left <= 0;
            bytes_in <= 0;
        end
        else
        begin
            if (byte_valid && byte_ready)
            begin
                predict_byte(byte_beat);
                bytes_in <= bytes_in + 1;
            end
            if (!(byte_valid && !byte_ready))
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    byte_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    byte_beat <= pending_bytes.pop_front();
                    byte_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready pattern, with one long hold-off while bytes keep coming
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_ready <= 1'b0;
            ready_mode <= RX_FULL;
            mode_timer <= 0;
            hold_left <= 0;
            held_once <= 1'b0;
        end
        else
        begin
            if (mode_timer == 0)
            begin
                ready_mode <= rx_mode_t'($urandom_range(0, 3));
                mode_timer <= $urandom_range(20, 80);
            end
            else
            begin
                mode_timer <= mode_timer - 1;
            end

            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                cp_ready <= 1'b0;
            end
            else if (!held_once && bytes_in >= LongHoldAfter)
            begin
                held_once <= 1'b1;
                hold_left <= LongHoldCycles;
                cp_ready <= 1'b0;
            end
            else
            begin
                case (ready_mode)
                    RX_FULL:   cp_ready <= 1'b1;
                    RX_MOSTLY: cp_ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: cp_ready <= ($urandom_range(0, 2) == 0);
                    default:   cp_ready <= ~cp_ready;
                endcase
            end
        end
    end

    // Code point monitor: compare each beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && cp_valid && cp_ready)
        begin
            if (expected_cps.size() == 0)
            begin
                $error("unexpected code point beat: code_point %h", cp_beat.code_point);
                error_count++;
            end
            else
            begin
                if (cp_beat.code_point !== expected_cps[0].code_point)
                begin
                    $error("code_point: expected %h, actual %h",
                           expected_cps[0].code_point, cp_beat.code_point);
                    error_count++;
                end
                if (cp_beat.last_of_run !== expected_cps[0].last_of_run)
                begin
                    $error("last_of_run: expected %b, actual %b",
                           expected_cps[0].last_of_run, cp_beat.last_of_run);
                    error_count++;
                end
                if (cp_beat.string_done !== expected_cps[0].string_done)
                begin
                    $error("string_done: expected %b, actual %b",
                           expected_cps[0].string_done, cp_beat.string_done);
                    error_count++;
                end
                void'(expected_cps.pop_front());
            end
            cps_checked++;
            if (cp_beat.string_done === 1'b1)
                strings_seen++;
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((byte_valid && byte_ready) || (cp_valid && cp_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= StallLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic wait_drained();
        @(negedge clk);
        while (pending_bytes.size() != 0 || byte_valid || expected_cps.size() != 0)
            @(negedge clk);
    endtask

    // Stimulus sequence
    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ASCII extremes
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        // two, three and four byte forms
        push_byte(8'hC2, 1'b0);
        push_byte(8'hA9, 1'b0);
        push_byte(8'hE2, 1'b0);
        push_byte(8'h82, 1'b0);
        push_byte(8'hAC, 1'b0);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h9F, 1'b0);
        push_byte(8'h98, 1'b0);
        push_byte(8'h80, 1'b1);
        // largest value the lenient rules allow, ending the string
        push_byte(8'hF7, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b1);
        // stray continuation, invalid lead
        push_byte(8'h80, 1'b0);
        push_byte(8'hF8, 1'b0);
        // four byte form broken by an invalid lead: four replacements
        push_byte(8'hF4, 1'b0);
        push_byte(8'h8F, 1'b0);
        push_byte(8'h8F, 1'b0);
        push_byte(8'hFF, 1'b0);
        // lead at end of string
        push_byte(8'hC3, 1'b1);
        // string ends inside a sequence
        push_byte(8'hE2, 1'b0);
        push_byte(8'h82, 1'b1);
        // plain ASCII ending a string
        push_byte(8'h41, 1'b1);
        wait_drained();

        // random text, long receiver hold-off falls in here
        while (pending_bytes.size() < RandomPerPhase)
            push_chunk();
        wait_drained();

        // second random phase after the sender has paused for a full drain
        while (pending_bytes.size() < RandomPerPhase)
            push_chunk();
        wait_drained();

        repeat (DrainCycles) @(negedge clk);
        if (expected_cps.size() != 0)
        begin
            $error("%0d expected code points never arrived", expected_cps.size());
            error_count++;
        end

        $display("Run covered %0d bytes and %0d code point beats (%0d replacements, %0d strings).",
                 bytes_in, cps_checked, fffd_expected, strings_seen);
        $display("Included one %0d-cycle receiver hold-off and a full sender drain between phases.",
                 LongHoldCycles);
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/u8d_pkg.sv
hw/rtl/utf8_stream_decoder_unit.sv
verif/tb_utf8_stream_decoder_unit.sv
